FILE: hw/rtl/etip_pkg.sv
// Shared types and constants for the elimination-tree inverse pattern block.
`default_nettype none
package etip_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int NODE_W        = 5;
    localparam int PAR_W         = 6;
    localparam int CNT_W         = 6;
    localparam int PTR_W         = 10;
    localparam int STEP_W        = 4;

    // Status codes of a result
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_PARENT = 2'd1;
    localparam logic [1:0] STAT_BAD_NODE   = 2'd2;

    // Input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_COUNT_DIAGONAL = 1'b0;
    localparam logic CFG_NODE_COUNT     = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    // Datapath action selected by one microcode word
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_FETCH,
        ACT_LOAD,
        ACT_ERR_NODE,
        ACT_QINIT,
        ACT_COUNT,
        ACT_QSUM,
        ACT_EMPTY,
        ACT_EMIT_DIAG,
        ACT_EMIT_WALK
    } act_t;

    // Jump condition of one microcode word
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_BAD_NODE,
        C_QUERY,
        C_CUR_ROOT,
        C_CNT_ZERO,
        C_LAST
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  stay;    // when the jump is not taken: 1 stay, 0 fall through
        step_t target;
    } uword_t;

    // Status from the datapath back to the sequencer
    typedef struct packed {
        logic bad_node;
        logic is_query;
        logic cur_root;
        logic cnt_zero;
        logic rem_one;
        logic diag;
        logic out_free;
        logic in_valid;
    } dp_flags_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        act_t act;
        logic go;
    } dp_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/etip_useq.sv
// Microcode store, step counter and jump logic of the sequencer.
`default_nettype none
module etip_useq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire etip_pkg::dp_flags_t flags,
    output etip_pkg::dp_ctrl_t       ctrl
);
    import etip_pkg::*;

    // Program addresses
    localparam step_t ST_FETCH  = 4'd0;
    localparam step_t ST_CHKND  = 4'd1;
    localparam step_t ST_DISP   = 4'd2;
    localparam step_t ST_LOAD   = 4'd3;
    localparam step_t ST_QINIT  = 4'd4;
    localparam step_t ST_COUNT  = 4'd5;
    localparam step_t ST_QSUM   = 4'd6;
    localparam step_t ST_DIAG   = 4'd7;
    localparam step_t ST_WALK   = 4'd8;
    localparam step_t ST_ERRND  = 4'd9;
    localparam step_t ST_EMPTY  = 4'd10;

    localparam int DEPTH = 2 ** STEP_W;

    // Program: first pass counts the ancestor chain, second pass emits it
    localparam uword_t UCODE [DEPTH] = '{
        '{ACT_FETCH,     C_NEVER,    1'b0, ST_FETCH},
        '{ACT_NOP,       C_BAD_NODE, 1'b0, ST_ERRND},
        '{ACT_NOP,       C_QUERY,    1'b0, ST_QINIT},
        '{ACT_LOAD,      C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_QINIT,     C_NEVER,    1'b0, ST_FETCH},
        '{ACT_COUNT,     C_CUR_ROOT, 1'b1, ST_QSUM},
        '{ACT_QSUM,      C_CNT_ZERO, 1'b0, ST_EMPTY},
        '{ACT_EMIT_DIAG, C_LAST,     1'b0, ST_FETCH},
        '{ACT_EMIT_WALK, C_LAST,     1'b1, ST_FETCH},
        '{ACT_ERR_NODE,  C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_EMPTY,     C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_NOP,       C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_NOP,       C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_NOP,       C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_NOP,       C_ALWAYS,   1'b0, ST_FETCH},
        '{ACT_NOP,       C_ALWAYS,   1'b0, ST_FETCH}
    };

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   emits;
    logic   stall;
    logic   taken;

    assign word = UCODE[step_reg];

    // Steps that load the output register wait for it to be free
    always_comb
    begin
        emits = (word.act == ACT_LOAD) || (word.act == ACT_ERR_NODE) ||
                (word.act == ACT_EMPTY) || (word.act == ACT_EMIT_WALK) ||
                ((word.act == ACT_EMIT_DIAG) && flags.diag);
        stall = ((word.act == ACT_FETCH) && !flags.in_valid) ||
                (emits && !flags.out_free);
    end

    // Jump condition
    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_BAD_NODE: taken = flags.bad_node;
            C_QUERY:    taken = flags.is_query;
            C_CUR_ROOT: taken = flags.cur_root;
            C_CNT_ZERO: taken = flags.cnt_zero;
            C_LAST:     taken = emits && flags.rem_one;
            default:    taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        priority if (stall)
            step_next = step_reg;
        else if (taken)
            step_next = word.target;
        else if (word.stay)
            step_next = step_reg;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_FETCH;
        else
            step_reg <= step_next;
    end

    assign ctrl.act = word.act;
    assign ctrl.go  = !stall;

endmodule
`default_nettype wire

FILE: hw/rtl/etip_dp.sv
// Datapath: item latch, parent and depth stores, counters and output register.
`default_nettype none
module etip_dp #(
    parameter int MAX_NODES = etip_pkg::MAX_NODES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire etip_pkg::dp_ctrl_t               ctrl,
    output etip_pkg::dp_flags_t                   flags,
    input  wire logic                             in_valid,
    input  wire logic                             func,
    input  wire logic [etip_pkg::NODE_W-1:0]      node,
    input  wire logic signed [etip_pkg::PAR_W-1:0] parent,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_index,
    input  wire logic [etip_pkg::CNT_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [etip_pkg::NODE_W-1:0]           row_index,
    output logic                                  row_valid,
    output logic [etip_pkg::CNT_W-1:0]            column_count,
    output logic [etip_pkg::PTR_W-1:0]            column_end,
    output logic                                  last,
    output logic [1:0]                            status
);
    import etip_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [PAR_W:0] MAX_W = (PAR_W + 1)'(MAX_NODES);
    localparam logic [PAR_W-1:0] NO_PARENT = '1;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [PTR_W-1:0] PTR_SAT = '1;

    // Configuration registers
    logic             diag_reg;
    logic [CNT_W-1:0] ncount_reg;

    // Latched item
    logic               func_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [PAR_W-1:0]   par_reg;

    // Stores
    logic [PAR_W-1:0] parent_store [MAX_NODES];
    logic [CNT_W-1:0] depth_store  [MAX_NODES];

    // Walk state
    logic [PAR_W-1:0] cur_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [PTR_W-1:0] ptr_reg;

    // Output register
    logic               out_valid_reg;
    logic [NODE_W-1:0]  row_reg;
    logic               rvalid_reg;
    logic [CNT_W-1:0]   ccount_reg;
    logic [PTR_W-1:0]   cend_reg;
    logic               last_reg;
    logic [1:0]         status_reg;

    logic [PAR_W:0]   limit;
    logic             bad_node;
    logic             par_root;
    logic             bad_par;
    logic [CNT_W:0]   dsum;
    logic [CNT_W-1:0] dnew;
    logic [PTR_W:0]   psum;
    logic [PTR_W-1:0] pnew;
    logic [PAR_W-1:0] par_of_node;
    logic [PAR_W-1:0] par_of_cur;
    logic             out_free;
    logic             act_go;
    logic             emit_now;

    // Range checks
    always_comb
    begin
        limit    = ((PAR_W + 1)'(ncount_reg) > MAX_W) ? MAX_W : (PAR_W + 1)'(ncount_reg);
        bad_node = (PAR_W + 1)'(node_reg) >= limit;
        par_root = par_reg[PAR_W-1];
        bad_par  = !par_root && ((par_reg <= PAR_W'(node_reg)) ||
                                 ((PAR_W + 1)'(par_reg) >= limit));
    end

    // New column count of a load, saturating
    always_comb
    begin
        dsum = (CNT_W + 1)'(depth_store[IW'(par_reg[NODE_W-1:0])]) + (CNT_W + 1)'(1);
        if (par_root)
            dnew = CNT_W'(diag_reg);
        else if (dsum[CNT_W])
            dnew = CNT_SAT;
        else
            dnew = dsum[CNT_W-1:0];
    end

    // Running pointer, saturating
    always_comb
    begin
        psum = (PTR_W + 1)'(ptr_reg) + (PTR_W + 1)'(cnt_reg);
        pnew = psum[PTR_W] ? PTR_SAT : psum[PTR_W-1:0];
    end

    // Single read port into the parent store per use
    assign par_of_node = parent_store[IW'(node_reg)];
    assign par_of_cur  = parent_store[IW'(cur_reg)];

    assign out_free = !out_valid_reg || out_ready;
    assign act_go   = ctrl.go;

    // Steps that load the output register
    always_comb
    begin
        emit_now = act_go && ((ctrl.act == ACT_LOAD) || (ctrl.act == ACT_ERR_NODE) ||
                              (ctrl.act == ACT_EMPTY) || (ctrl.act == ACT_EMIT_WALK) ||
                              ((ctrl.act == ACT_EMIT_DIAG) && diag_reg));
    end

    always_comb
    begin
        flags.bad_node = bad_node;
        flags.is_query = (func_reg == FUNC_QUERY);
        flags.cur_root = cur_reg[PAR_W-1];
        flags.cnt_zero = (cnt_reg == '0);
        flags.rem_one  = (rem_reg == CNT_W'(1));
        flags.diag     = diag_reg;
        flags.out_free = out_free;
        flags.in_valid = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg      <= 1'b1;
            ncount_reg    <= CNT_W'(32);
            func_reg      <= FUNC_LOAD;
            node_reg      <= '0;
            par_reg       <= '0;
            cur_reg       <= NO_PARENT;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            rvalid_reg    <= 1'b0;
            ccount_reg    <= '0;
            cend_reg      <= '0;
            last_reg      <= 1'b0;
            status_reg    <= STAT_OK;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                parent_store[i] <= NO_PARENT;
                depth_store[i]  <= '0;
            end
        end
        else
        begin
            // Configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_COUNT_DIAGONAL: diag_reg   <= cfg_data[0];
                    CFG_NODE_COUNT:     ncount_reg <= cfg_data;
                    default:            ncount_reg <= ncount_reg;
                endcase
            end

            // Output register loads on an emitting step, drains on transfer
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (act_go)
            begin
                unique case (ctrl.act)
                    ACT_FETCH:
                    begin
                        func_reg <= func;
                        node_reg <= node;
                        par_reg  <= parent;
                    end
                    ACT_LOAD:
                    begin
                        row_reg       <= '0;
                        rvalid_reg    <= 1'b0;
                        cend_reg      <= '0;
                        last_reg      <= 1'b1;
                        if (bad_par)
                        begin
                            ccount_reg <= '0;
                            status_reg <= STAT_BAD_PARENT;
                        end
                        else
                        begin
                            parent_store[IW'(node_reg)] <= par_root ? NO_PARENT : par_reg;
                            depth_store[IW'(node_reg)]  <= dnew;
                            ptr_reg    <= '0;
                            ccount_reg <= dnew;
                            status_reg <= STAT_OK;
                        end
                    end
                    ACT_ERR_NODE:
                    begin
                        row_reg       <= '0;
                        rvalid_reg    <= 1'b0;
                        ccount_reg    <= '0;
                        cend_reg      <= '0;
                        last_reg      <= 1'b1;
                        status_reg    <= STAT_BAD_NODE;
                    end
                    ACT_QINIT:
                    begin
                        cnt_reg <= CNT_W'(diag_reg);
                        cur_reg <= par_of_node;
                    end
                    ACT_COUNT:
                    begin
                        if (!cur_reg[PAR_W-1])
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            cur_reg <= par_of_cur;
                        end
                    end
                    ACT_QSUM:
                    begin
                        ptr_reg <= pnew;
                        rem_reg <= cnt_reg;
                        cur_reg <= par_of_node;
                    end
                    ACT_EMPTY:
                    begin
                        row_reg       <= '0;
                        rvalid_reg    <= 1'b0;
                        ccount_reg    <= '0;
                        cend_reg      <= ptr_reg;
                        last_reg      <= 1'b1;
                        status_reg    <= STAT_OK;
                    end
                    ACT_EMIT_DIAG:
                    begin
                        if (diag_reg)
                        begin
                            row_reg       <= node_reg;
                            rvalid_reg    <= 1'b1;
                            ccount_reg    <= cnt_reg;
                            cend_reg      <= ptr_reg;
                            last_reg      <= (rem_reg == CNT_W'(1));
                            status_reg    <= STAT_OK;
                            rem_reg       <= rem_reg - CNT_W'(1);
                        end
                    end
                    ACT_EMIT_WALK:
                    begin
                        row_reg       <= cur_reg[NODE_W-1:0];
                        rvalid_reg    <= 1'b1;
                        ccount_reg    <= cnt_reg;
                        cend_reg      <= ptr_reg;
                        last_reg      <= (rem_reg == CNT_W'(1));
                        status_reg    <= STAT_OK;
                        rem_reg       <= rem_reg - CNT_W'(1);
                        cur_reg       <= par_of_cur;
                    end
                    ACT_NOP:
                    begin
                        cur_reg <= cur_reg;
                    end
                    default:
                    begin
                        cur_reg <= cur_reg;
                    end
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_index    = row_reg;
    assign row_valid    = rvalid_reg;
    assign column_count = ccount_reg;
    assign column_end   = cend_reg;
    assign last         = last_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/etree_inverse_pattern_top.sv
// Top level of the elimination-tree inverse pattern block.
// A load stores one node's parent (negative means root) and its column count,
// and answers with one result; load nodes from highest to lowest. A query emits
// the column's rows: the diagonal when count_diagonal is 1, then each ancestor
// up to the root, every result carrying the column count and the running
// column-end pointer (cleared by each good load). Items are handled one at a
// time under a small microcoded sequencer. A query walks the ancestor chain
// twice, once to count it and once to emit it. Results sit in an output
// register, so a stalled consumer holds the walk. Configuration is accepted
// every cycle.
`default_nettype none
module etree_inverse_pattern_top #(
    parameter int MAX_NODES = etip_pkg::MAX_NODES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic [etip_pkg::NODE_W-1:0]       node,
    input  wire logic signed [etip_pkg::PAR_W-1:0] parent,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [etip_pkg::NODE_W-1:0]            row_index,
    output logic                                   row_valid,
    output logic [etip_pkg::CNT_W-1:0]             column_count,
    output logic [etip_pkg::PTR_W-1:0]             column_end,
    output logic                                   last,
    output logic [1:0]                             status,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [etip_pkg::CNT_W-1:0]        cfg_data
);
    import etip_pkg::*;

    dp_flags_t flags;
    dp_ctrl_t  ctrl;

    // Only the fetch step takes an input transfer
    assign in_ready  = (ctrl.act == ACT_FETCH);
    assign cfg_ready = 1'b1;

    etip_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    etip_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .flags        (flags),
        .in_valid     (in_valid),
        .func         (func),
        .node         (node),
        .parent       (parent),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_index    (row_index),
        .row_valid    (row_valid),
        .column_count (column_count),
        .column_end   (column_end),
        .last         (last),
        .status       (status)
    );

endmodule
`default_nettype wire
